// ----- sv/sorted_table_exact_search_defines.svh -----
// assertion macros shared by the sorted table search rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef SORTED_TABLE_EXACT_SEARCH_DEFINES_SVH
`define SORTED_TABLE_EXACT_SEARCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sts_pkg.sv -----
// package for the sorted table search: payload structs, opcodes, fsm states
// no dependencies
`timescale 1ns / 1ps

package sts_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int DATA_W          = 32;
	localparam int IDX_W           = 10;
	localparam int COUNT_W         = 11;
	// wide enough for any legal depth and for a raw count or index
	localparam int XW              = 17;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef struct packed {
		logic                     operation;
		logic [IDX_W-1:0]         entry_index;
		logic signed [DATA_W-1:0] data_value;
	} sts_in_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
	} sts_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_FINISH
	} sts_state_t;

endpackage

// ----- sv/sts_value_ram.sv -----
// single-port-write, single-port-read table memory with registered read data
// depends on sts_pkg for the data width
`timescale 1ns / 1ps

module sts_value_ram #(
	parameter int DEPTH = sts_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = 10
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [sts_pkg::DATA_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [sts_pkg::DATA_W-1:0] rd_data
);
	import sts_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/sorted_table_exact_search.sv -----
// sorted table exact search: top level with request fsm and binary search control
// depends on sts_pkg, sts_value_ram and sorted_table_exact_search_defines.svh
`timescale 1ns / 1ps

// Binary search over a table of signed 32-bit values kept in ascending order.
// A write request (operation 0) stores data_value at entry_index and gives no
// result; an index at or above TABLE_DEPTH is dropped. A search request
// (operation 1) looks for data_value among entries 0 to entry_count-1
// (entry_count above TABLE_DEPTH acts as TABLE_DEPTH) and gives one result:
// found and match_index (0 when not found). Each probe is a synchronous table
// read followed by a compare, and a search makes at most floor(log2(count))+1
// probes, none for an empty table; every probe waits on its read. Only one
// request is in flight; in_stall is high from the accept of a search until the
// result has been moved into the output register, which then waits for the
// consumer while the next request is taken. The table has no reset; a search
// must only probe entries that were written. entry_count is written through
// cfg_write_en and cfg_write_data and may only change while no search is
// running.
module sorted_table_exact_search #(
	parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [sts_pkg::COUNT_W-1:0] cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  sts_pkg::sts_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output sts_pkg::sts_out_t           out_data
);
	import sts_pkg::*;

`include "sorted_table_exact_search_defines.svh"

	// address width and width of a count 0..TABLE_DEPTH
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// configuration
	logic [COUNT_W-1:0] entry_count_q;

	// search state
	sts_state_t               state_q, state_d;
	logic [CW-1:0]            lo_q, lo_d;      // first live entry
	logic [CW-1:0]            hi_q, hi_d;      // one past the last live entry
	logic signed [DATA_W-1:0] key_q;
	logic                     hit_q, hit_d;
	logic [AW-1:0]            where_q, where_d;
	logic [AW-1:0]            mid_s1;          // address of the read in flight

	// output register
	logic     out_valid_q;
	sts_out_t out_q;

	// memory side
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic [AW-1:0]     mid;
	logic [DATA_W-1:0] rd_data;

	logic            accept;
	logic            load_out;
	logic            res_ready;
	logic [XW-1:0]   idx_ext;
	logic [XW-1:0]   ec_ext;
	logic [XW-1:0]   cnt_clamp;
	logic [CW-1:0]   count_w;
	logic [CW:0]     mid_sum;
	logic [CW-1:0]   mid_full;
	logic [CW-1:0]   mid_plus;

	// clamp entry_count to the table depth
	assign ec_ext    = XW'(entry_count_q);
	assign cnt_clamp = (ec_ext > XW'(TABLE_DEPTH)) ? XW'(TABLE_DEPTH) : ec_ext;
	assign count_w   = cnt_clamp[CW-1:0];

	// midpoint floor((lo + hi_incl) / 2) with hi_incl = hi_q - 1, lo_q < hi_q here
	assign mid_sum  = (CW+1)'(lo_q) + (CW+1)'(hi_q) - (CW+1)'(1);
	assign mid_full = mid_sum[CW:1];
	assign mid      = mid_full[AW-1:0];
	assign mid_plus = CW'(mid_s1) + CW'(1);

	// write path, taken only while idle so it never meets a probe read
	assign idx_ext = XW'(in_data.entry_index);
	assign wr_addr = idx_ext[AW-1:0];
	assign wr_en   = accept && (in_data.operation == OP_WRITE)
		&& (idx_ext < XW'(TABLE_DEPTH));

	// output register frees when empty or when its result leaves this cycle
	assign res_ready = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		hit_d    = hit_q;
		where_d  = where_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && (in_data.operation == OP_SEARCH)) begin
					lo_d    = '0;
					hi_d    = count_w;
					hit_d   = 1'b0;
					where_d = '0;
					// empty table: nothing to probe
					state_d = (count_w == '0) ? S_FINISH : S_READ;
				end
			end
			S_READ: begin
				rd_en   = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if ($signed(rd_data) == key_q) begin
					hit_d   = 1'b1;
					where_d = mid_s1;
					state_d = S_FINISH;
				end else begin
					if ($signed(rd_data) < key_q) begin
						lo_d = mid_plus;
					end else begin
						hi_d = CW'(mid_s1);
					end
					state_d = (lo_d < hi_d) ? S_READ : S_FINISH;
				end
			end
			S_FINISH: begin
				if (res_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				entry_count_q <= cfg_write_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search payload, no reset needed
	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		hit_q   <= hit_d;
		where_q <= where_d;
		if (accept) begin
			key_q <= in_data.data_value;
		end
		if (rd_en) begin
			mid_s1 <= mid;
		end
		if (load_out) begin
			out_q.found       <= hit_q;
			out_q.match_index <= IDX_W'(where_q);
		end
	end

	sts_value_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_value_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_data.data_value),
		.rd_en   (rd_en),
		.rd_addr (mid),
		.rd_data (rd_data)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`STS_ASSERT_NOW(a_ready_only_idle, !in_stall, state_q == S_IDLE, "request taken while busy")
	`STS_ASSERT_NOW(a_no_rd_wr_overlap, rd_en, !wr_en, "table read and write in one cycle")
	`STS_ASSERT_NOW(a_live_range_read, state_q == S_READ, lo_q < hi_q, "probe of an empty range")
	`STS_ASSERT_NOW(a_probe_in_count, state_q == S_READ, CW'(mid) < count_w, "probe beyond entry count")
	`STS_ASSERT_NEXT(a_load_from_finish, load_out, out_valid_q && (state_q == S_IDLE), "result load lost")

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the sorted table exact search block
// depends on sts_pkg and sorted_table_exact_search
`timescale 1ns / 1ps

module tb;
	import sts_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	// cycles to let pass after the last result before a register write or the end
	localparam int SETTLE = 30;
	// cycles without any accepted request, result or register write
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1500;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write_en = 1'b0;
	logic [COUNT_W-1:0]   cfg_write_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	sts_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	sts_out_t             out_data;

	// requests waiting for the driver, and search answers waiting for the block
	sts_in_t              pending[$];
	sts_out_t             search_answers[$];

	// predictor state: table contents and entry count as the block should hold them
	logic signed [DATA_W-1:0] model_table[DEPTH];
	int                   model_count = 0;

	// generator view of the table: what it will hold once queued writes land
	logic signed [DATA_W-1:0] plan_table[DEPTH];
	bit                   plan_mask[DEPTH];

	int                   request_total = 0;
	int                   requests_taken = 0;
	int                   fail_count = 0;
	int                   burst_left = 0;
	int                   gap_left = 0;
	int                   stall_mode = 0;
	int                   stall_hold = 0;

	sorted_table_exact_search #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	// binary search over the predicted table, midpoint is floor of (low+high)/2
	function automatic sts_out_t binary_lookup(input logic signed [DATA_W-1:0] key);
		int lo;
		int hi;
		int mid;
		int span;
		sts_out_t res;
		res = '0;
		// count above depth acts as a full table
		span = (model_count > DEPTH) ? DEPTH : model_count;
		lo = 0;
		hi = span - 1;
		while (lo <= hi && !res.found) begin
			mid = (lo + hi) / 2;
			if (model_table[mid] == key) begin
				// first equal entry probed wins, even among duplicates
				res.found = 1'b1;
				res.match_index = IDX_W'(mid);
			end else if (model_table[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return res;
	endfunction

	// apply one accepted request to the predictor
	task automatic apply_request(input sts_in_t req);
		if (req.operation == OP_WRITE) begin
			model_table[req.entry_index] = req.data_value;
		end else begin
			search_answers.push_back(binary_lookup(req.data_value));
		end
		requests_taken++;
	endtask

	task automatic log_failure(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	// driver: bursts of requests with random gaps, payload held while stalled
	always @(posedge clk) begin : driver
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall)
				apply_request(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					in_data <= pending.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// new burst, sometimes back to back with no gap at all
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted result against the oldest answer, stalls on its own pattern
	always @(posedge clk) begin : monitor
		sts_out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (search_answers.size() == 0) begin
					log_failure($sformatf("unexpected result found=%0d match_index=%0d",
						out_data.found, out_data.match_index));
				end else begin
					want = search_answers.pop_front();
					if (out_data.found !== want.found)
						log_failure($sformatf("found mismatch: expected %0d actual %0d",
							want.found, out_data.found));
					if (out_data.match_index !== want.match_index)
						log_failure($sformatf("match_index mismatch: expected %0d actual %0d",
							want.match_index, out_data.match_index));
				end
			end
			// stall pattern: free running, short periodic stalls, coin flips, alternating
			if (stall_hold > 0) begin
				stall_hold--;
			end else begin
				stall_mode = $urandom_range(0, 3);
				stall_hold = $urandom_range(4, 60);
			end
			case (stall_mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ((stall_hold % 16) < 3);
				end
				2: begin
					out_stall <= 1'($urandom_range(0, 1));
				end
				default: begin
					out_stall <= stall_hold[0];
				end
			endcase
		end
	end

	// watchdog: ends the run when nothing moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_write_en || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic push_write(input int idx, input logic signed [DATA_W-1:0] val);
		sts_in_t req;
		req.operation = OP_WRITE;
		req.entry_index = IDX_W'(idx);
		req.data_value = val;
		plan_table[idx] = val;
		plan_mask[idx] = 1'b1;
		pending.push_back(req);
		request_total++;
	endtask

	task automatic push_search(input logic signed [DATA_W-1:0] key);
		sts_in_t req;
		req.operation = OP_SEARCH;
		// index is ignored on search, so let it toggle freely
		req.entry_index = IDX_W'($urandom);
		req.data_value = key;
		pending.push_back(req);
		request_total++;
	endtask

	// block idle: every request taken, every answer delivered, then a settle pause
	task automatic wait_drained();
		while (!(requests_taken == request_total && search_answers.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_entry_count(input int n);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= COUNT_W'(n);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		model_count = n;
	endtask

	// length of the written run starting at index zero
	function automatic int prefix_len();
		int n;
		n = 0;
		while (n < DEPTH && plan_mask[n])
			n++;
		return n;
	endfunction

	// ascending values in entries 0..n-1, with duplicates, spread or dense
	task automatic write_sorted_run(input int n);
		longint v;
		longint step_max;
		int i;
		int idx;
		bit descend;
		if ($urandom_range(0, 3) == 0)
			step_max = 3;
		else
			step_max = (longint'(1) << 33) / n;
		if (step_max > 64'hFFFF_FFFF)
			step_max = 64'hFFFF_FFFF;
		v = longint'(VAL_MIN) + $urandom_range(0, 32'(step_max));
		for (i = 0; i < n; i++) begin
			plan_table[i] = v[DATA_W-1:0];
			if ($urandom_range(0, 7) != 0)
				v += $urandom_range(1, 32'(step_max));
			if (v > longint'(VAL_MAX))
				v = longint'(VAL_MAX);
		end
		// write order does not matter to the final contents
		descend = 1'($urandom_range(0, 1));
		for (i = 0; i < n; i++) begin
			idx = descend ? n - 1 - i : i;
			push_write(idx, plan_table[idx]);
		end
	endtask

	// search key: mostly hits, then near misses, extremes and random values
	function automatic logic signed [DATA_W-1:0] pick_key(input int span);
		int r;
		logic signed [DATA_W-1:0] k;
		r = $urandom_range(0, 9);
		k = $urandom;
		if (span > 0 && r < 5)
			k = plan_table[$urandom_range(0, span - 1)];
		else if (span > 0 && r < 7)
			k = plan_table[$urandom_range(0, span - 1)] + ((r == 5) ? 1 : -1);
		else if (r == 7)
			k = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		else if (r == 8)
			k = $urandom_range(0, 1) ? 0 : -1;
		return k;
	endfunction

	initial begin : stimulus
		int kind;
		int n;
		int bound;
		int count;
		int span;
		int idx;
		bit full_done;
		bit beyond_done;
		bit go_beyond;
		full_done = 1'b0;
		beyond_done = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table gives not found at index zero
		set_entry_count(0);
		push_search(0);

		// extremes of the value range, with a duplicate zero pair
		push_write(0, VAL_MIN);
		push_write(1, VAL_MIN + 1);
		push_write(2, -1);
		push_write(3, 0);
		push_write(4, 0);
		push_write(5, 1);
		push_write(6, VAL_MAX - 1);
		push_write(7, VAL_MAX);
		// highest table index
		push_write(DEPTH - 1, VAL_MAX);
		wait_drained();
		set_entry_count(8);
		push_search(VAL_MIN);
		push_search(VAL_MAX);
		push_search(0);
		push_search(-1);
		push_search(1);
		push_search(VAL_MAX - 1);
		push_search(2);
		push_search(VAL_MIN + 2);

		// single entry table
		wait_drained();
		set_entry_count(1);
		push_search(VAL_MIN);
		push_search(VAL_MAX);

		// out of order table: the probe sequence runs unchanged
		push_write(3, VAL_MAX);
		wait_drained();
		set_entry_count(8);
		push_search(0);
		push_search(VAL_MAX);
		push_search(-1);

		// random phases: count set while idle, then writes, then searches
		while (request_total < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			n = 0;
			go_beyond = 1'b0;
			if (!full_done && request_total >= 300) begin
				// whole table filled once so any count is legal from here on
				n = DEPTH;
				kind = 0;
				full_done = 1'b1;
			end else if (full_done && !beyond_done) begin
				// largest count, beyond the depth
				kind = 9;
				beyond_done = 1'b1;
				go_beyond = 1'b1;
			end else if (kind < 8) begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
			end
			bound = prefix_len();
			if (n > bound)
				bound = n;
			// never let a search reach an entry that was never written
			if (go_beyond && bound == DEPTH)
				count = 2047;
			else if (bound == DEPTH && $urandom_range(0, 3) == 0)
				count = $urandom_range(DEPTH, 2047);
			else if (kind < 6)
				count = n;
			else
				count = $urandom_range(0, bound);

			wait_drained();
			set_entry_count(count);
			if (n > 0)
				write_sorted_run(n);
			// noise writes can break the ordering anywhere in the table
			if (kind >= 6 && kind != 9) begin
				repeat ($urandom_range(1, 6)) begin
					idx = $urandom_range(0, DEPTH - 1);
					push_write(idx, $urandom);
				end
			end
			span = (count > DEPTH) ? DEPTH : count;
			repeat ((n == DEPTH) ? 80 : $urandom_range(1, 30))
				push_search(pick_key(span));
		end

		wait_drained();
		if (fail_count == 0 && search_answers.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sts_pkg.sv
sv/sts_value_ram.sv
sv/sorted_table_exact_search.sv
tb/tb.sv
